[hdl/uvf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uvf_pkg
// Shared types and constants for the duplicate-rejecting FIFO.
// ----------------------------------------------------------------------------
package uvf_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int VALUE_W       = 32;
    localparam int ENTRY_W       = 31;

    // request kinds carried on s_tuser
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    typedef enum logic [2:0] {
        STAT_OK        = 3'd0,
        STAT_NEGATIVE  = 3'd1,
        STAT_DUPLICATE = 3'd2,
        STAT_FULL      = 3'd3,
        STAT_EMPTY     = 3'd4
    } status_t;

    // controller -> datapath
    typedef struct packed {
        logic load;     // latch a new request, rewind the scan
        logic scan;     // step the scan over stored entries
        logic commit;   // update queue state and load the output register
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic scan_done;
        logic out_free;
    } sts_t;

endpackage

[hdl/uvf_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uvf_ctrl
// Sequencer: accept a request, run the entry scan, commit the result.
// ----------------------------------------------------------------------------
module uvf_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  uvf_pkg::sts_t sts,
    output uvf_pkg::cmd_t cmd
);
    import uvf_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SCAN   = 3'b010,
        S_COMMIT = 3'b100
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE) && aresetn;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                cmd.scan = 1'b1;
                if (sts.scan_done) begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT: begin
                // hold until the output register can take the result
                if (sts.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

[hdl/uvf_dpath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uvf_dpath
// Entry memory, ring pointers, duplicate scan and output register.
// ----------------------------------------------------------------------------
module uvf_dpath #(
    parameter int DEPTH = uvf_pkg::DEPTH_DEFAULT
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  uvf_pkg::cmd_t                cmd,
    output uvf_pkg::sts_t                sts,
    input  logic                         in_op,
    input  logic [uvf_pkg::VALUE_W-1:0]  in_value,
    output logic                         out_valid,
    input  logic                         out_ready,
    output uvf_pkg::status_t             out_status,
    output logic [uvf_pkg::ENTRY_W-1:0]  out_value
);
    import uvf_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

    logic [ENTRY_W-1:0] mem [DEPTH];

    logic [AW-1:0]      head_reg, head_next;
    logic [AW-1:0]      tail_reg, tail_next;
    logic [CW-1:0]      occ_reg, occ_next;
    logic [AW-1:0]      scan_ptr_reg;
    logic [CW-1:0]      scan_cnt_reg;
    logic [CW-1:0]      limit_reg;
    logic               rd_vld_reg;
    logic [ENTRY_W-1:0] rd_data_reg;
    logic               match_reg;
    logic               op_reg;
    logic [VALUE_W-1:0] value_reg;
    logic               out_vld_reg;
    status_t            out_status_reg, status_next;
    logic [ENTRY_W-1:0] out_value_reg, result_next;
    logic               issue;
    logic               do_write;
    logic               do_pop;
    logic [CW-1:0]      limit_next;

    function automatic logic [AW-1:0] bump(input logic [AW-1:0] p);
        return (p == LAST_SLOT) ? '0 : p + AW'(1);
    endfunction

    // how many entries the scan reads for the incoming request
    always_comb begin
        if (in_op == OP_REMOVE) begin
            limit_next = (occ_reg != '0) ? CW'(1) : '0;
        end else if (in_value[VALUE_W-1]) begin
            limit_next = '0;
        end else begin
            limit_next = occ_reg;
        end
    end

    assign issue         = cmd.scan && (scan_cnt_reg != limit_reg);
    assign sts.scan_done = (scan_cnt_reg == limit_reg) && !rd_vld_reg;
    assign sts.out_free  = !out_vld_reg || out_ready;

    // request registers and scan bookkeeping
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg       <= in_op;
            value_reg    <= in_value;
            limit_reg    <= limit_next;
            scan_ptr_reg <= head_reg;
            scan_cnt_reg <= '0;
            match_reg    <= 1'b0;
        end else begin
            if (issue) begin
                scan_ptr_reg <= bump(scan_ptr_reg);
                scan_cnt_reg <= scan_cnt_reg + CW'(1);
            end
            if (rd_vld_reg && (rd_data_reg == value_reg[ENTRY_W-1:0])) begin
                match_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_vld_reg <= 1'b0;
        end else begin
            rd_vld_reg <= issue;
        end
    end

    // entry memory: one write port at the tail, one registered read port
    always_ff @(posedge aclk) begin
        if (do_write) begin
            mem[tail_reg] <= value_reg[ENTRY_W-1:0];
        end
        if (issue) begin
            rd_data_reg <= mem[scan_ptr_reg];
        end
    end

    // decide the outcome
    always_comb begin
        status_next = STAT_OK;
        result_next = '0;
        do_write    = 1'b0;
        do_pop      = 1'b0;
        if (op_reg == OP_REMOVE) begin
            if (occ_reg == '0) begin
                status_next = STAT_EMPTY;
            end else begin
                result_next = rd_data_reg;
                do_pop      = cmd.commit;
            end
        end else if (value_reg[VALUE_W-1]) begin
            status_next = STAT_NEGATIVE;
        end else if (match_reg) begin
            status_next = STAT_DUPLICATE;
        end else if (occ_reg == FULL_CNT) begin
            status_next = STAT_FULL;
        end else begin
            result_next = value_reg[ENTRY_W-1:0];
            do_write    = cmd.commit;
        end
    end

    always_comb begin
        head_next = head_reg;
        tail_next = tail_reg;
        occ_next  = occ_reg;
        if (do_write) begin
            tail_next = bump(tail_reg);
            occ_next  = occ_reg + CW'(1);
        end else if (do_pop) begin
            head_next = bump(head_reg);
            occ_next  = occ_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg    <= '0;
            tail_reg    <= '0;
            occ_reg     <= '0;
            out_vld_reg <= 1'b0;
        end else begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            occ_reg  <= occ_next;
            if (cmd.commit) begin
                out_vld_reg <= 1'b1;
            end else if (out_ready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            out_status_reg <= status_next;
            out_value_reg  <= result_next;
        end
    end

    assign out_valid  = out_vld_reg;
    assign out_status = out_status_reg;
    assign out_value  = out_value_reg;

endmodule

[hdl/unique_value_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// unique_value_fifo
// FIFO of non-negative 31-bit values that holds each value at most once.
// ----------------------------------------------------------------------------
//
//  channel   direction  payload
//  --------  ---------  -------------------------------------------------
//  s_*       in         tuser: op (0 insert, 1 remove); tdata: value
//  m_*       out        tuser: status; tdata: result_value, zero-padded
//
//  One request is handled at a time: the next is accepted after the last
//  commits. A rejected negative insert, a remove from an empty queue or an
//  insert into an empty queue reads no entry; a remove from a non-empty
//  queue reads the head entry; an insert reads every held entry once
//  through the single registered read port of the entry memory.
//  Reset: aresetn low empties the queue (pointers and count cleared) and
//  holds s_tready low; the entry memory itself is not cleared.
//  Stalls: a finished result waits in the output register while the next
//  request is accepted; the commit step holds until that register drains.
//
module unique_value_fifo #(
    parameter int DEPTH = uvf_pkg::DEPTH_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    // request channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value (signed)
    input  logic        s_tuser,   // [0] op
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [30:0] result_value, [31] zero
    output logic [2:0]  m_tuser    // [2:0] status
);
    import uvf_pkg::*;

    cmd_t               cmd;
    sts_t               sts;
    status_t            out_status;
    logic [ENTRY_W-1:0] out_value;

    // sequencer: idle -> scan -> commit
    uvf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // entries, ring pointers, duplicate compare, output register
    uvf_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .sts        (sts),
        .in_op      (s_tuser),
        .in_value   (s_tdata),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_status (out_status),
        .out_value  (out_value)
    );

    // pad the 31-bit result up to a whole-byte data bus
    assign m_tdata = {1'b0, out_value};
    assign m_tuser = out_status;

endmodule
